>>> rtl/core/wspid_pkg.sv
// Shared types and constants for the wheel speed PID controller with setpoint ramp.
`default_nettype none
package wspid_pkg;

  localparam int GAIN_W   = 12;
  localparam int OFF_W    = 8;
  localparam int LIM_W    = 10;
  localparam int SPD_W    = 14;
  localparam int FILT_W   = 22;
  localparam int INTEG_W  = 24;
  localparam int PERR_W   = 16;
  localparam int ERR_W    = 15;
  localparam int DERR_W   = 17;
  localparam int ACC_W    = 40;
  localparam int DUTY_W   = 8;
  localparam int ALPHA_W  = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic [ACC_W-1:0] DUTY_SAT = ACC_W'(255 * 81920);
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP    = 3'd0,
    CFG_KI    = 3'd1,
    CFG_KD    = 3'd2,
    CFG_OFF   = 3'd3,
    CFG_SLOPE = 3'd4,
    CFG_ILIM  = 3'd5,
    CFG_STEP  = 3'd6,
    CFG_ALPHA = 3'd7
  } cfg_idx_t;

endpackage
`default_nettype wire

>>> rtl/core/wheel_speed_pid_with_ramp.sv
// Wheel speed PID controller: bit-serial filter, ramp, feedforward and PID per tick.
// Sequence per item: bit-serial filter multiply, setpoint ramp, error, then four products
// of one 12-bit gain each (feedforward slope, kp, ki, kd) and an 11-step divide by 5.
// A wheel that saturates the drive skips the divide, a wheel switched off skips all after
// the ramp, and a wheel number out of range goes straight to the output.
// One item in flight: a new input is taken only when the block is idle.
// Reset (rst_n, synchronous): all wheel state zero, gains zero, ramp step 72, alpha 51.
`default_nettype none
module wheel_speed_pid_with_ramp #(
  parameter int WHEELS = 4
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  // [1:0] wheel, [15:2] measured_speed, [29:16] target_speed
  input  wire [wspid_pkg::IN_DATA_W-1:0] in_tdata,
  output logic       out_tvalid,
  input  wire        out_tready,
  // [1:0] wheel_out, [9:2] duty, [23:10] filtered_speed, [37:24] slewed_setpoint
  output logic [wspid_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [wspid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [wspid_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDXW = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam int ACC_W = wspid_pkg::ACC_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_FILT, S_RAMP, S_ERR, S_PREP, S_MAC, S_UPD, S_DIV, S_DONE
  } state_t;

  state_t state_r;

  logic [47:0] kp_r, ki_r, kd_r, slope_r;
  logic [31:0] off_r;
  logic [39:0] ilim_r;
  logic [13:0] step_r;
  logic [8:0]  alpha_r;

  logic [13:0] sp_mem   [WHEELS];
  logic [23:0] integ_mem[WHEELS];
  logic [15:0] prev_mem [WHEELS];
  logic [21:0] filt_mem [WHEELS];

  logic [1:0]  wheel_r;
  logic [13:0] meas_r, target_r, fs_r, sp_r;
  logic signed [ACC_W-1:0] acc_r, opnd_r;
  logic [11:0] gain_r;
  logic [3:0]  cnt_r;
  logic [1:0]  prod_r;
  logic signed [14:0] e_r;
  logic signed [16:0] de_r;
  logic [7:0]  duty_r, quo_r;
  logic [2:0]  rem_r;
  logic [10:0] divx_r;
  logic        out_valid_r;
  logic [wspid_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [IDXW-1:0] widx;
  assign widx = wheel_r[IDXW-1:0];

  // operand selection and helpers
  logic [8:0]  alpha_eff;
  logic signed [22:0] fdiff;
  logic signed [23:0] fnew;
  logic [14:0] sp_up;
  logic [13:0] sp_new;
  logic signed [14:0] e_new;
  logic signed [16:0] de_new;
  logic [11:0] lane_kp, lane_ki, lane_kd, lane_slope;
  logic [7:0]  lane_off;
  logic [9:0]  lane_lim;
  logic [18:0] lim;
  logic signed [24:0] ival;
  logic signed [ACC_W-1:0] p_opnd, ff_init, acc_step;
  logic [11:0] p_gain;
  logic [3:0]  div_t;
  logic        div_ge;

  always_comb begin
    alpha_eff = (alpha_r > wspid_pkg::ALPHA_MAX) ? wspid_pkg::ALPHA_MAX : alpha_r;
    fdiff = $signed({1'b0, meas_r, 8'd0}) - $signed({1'b0, filt_mem[widx]});
    fnew = $signed({2'b00, filt_mem[widx]}) + $signed(acc_r[31:8]);
    sp_up = {1'b0, sp_mem[widx]} + {1'b0, step_r};
    sp_new = sp_mem[widx];
    if (sp_mem[widx] < target_r) begin
      sp_new = (sp_up > {1'b0, target_r}) ? target_r : sp_up[13:0];
    end else if (sp_mem[widx] > target_r) begin
      sp_new = ((sp_mem[widx] < step_r) || (sp_mem[widx] - step_r < target_r)) ?
               target_r : sp_mem[widx] - step_r;
    end
    e_new = $signed({1'b0, sp_r}) - $signed({1'b0, fs_r});
    de_new = 17'(e_new) - 17'($signed(prev_mem[widx]));
    lane_kp    = kp_r[wheel_r*12 +: 12];
    lane_ki    = ki_r[wheel_r*12 +: 12];
    lane_kd    = kd_r[wheel_r*12 +: 12];
    lane_slope = slope_r[wheel_r*12 +: 12];
    lane_off   = off_r[wheel_r*8 +: 8];
    lane_lim   = ilim_r[wheel_r*10 +: 10];
    lim = {lane_lim, 8'd0} + {2'b00, lane_lim, 6'd0};
    ival = 25'($signed(integ_mem[widx])) + 25'(e_r);
    ff_init = (sp_r != 14'd0) ?
              $signed(ACC_W'({lane_off, 16'd0}) + ACC_W'({lane_off, 14'd0})) : '0;
    case (prod_r)
      2'd0: begin
        p_opnd = (sp_r != 14'd0) ?
                 $signed(ACC_W'({sp_r, 4'd0}) + ACC_W'({sp_r, 2'd0})) : '0;
        p_gain = lane_slope;
      end
      2'd1: begin
        p_opnd = (ACC_W'(e_r) <<< 4) + (ACC_W'(e_r) <<< 2);
        p_gain = lane_kp;
      end
      2'd2: begin
        p_opnd = ACC_W'($signed(integ_mem[widx]));
        p_gain = lane_ki;
      end
      default: begin
        p_opnd = (ACC_W'(de_r) <<< 8) + (ACC_W'(de_r) <<< 7) + (ACC_W'(de_r) <<< 4);
        p_gain = lane_kd;
      end
    endcase
    acc_step = gain_r[0] ? acc_r + opnd_r : acc_r;
    div_t = {rem_r, divx_r[10]};
    div_ge = (div_t >= 4'd5);
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= '0; ki_r <= '0; kd_r <= '0; slope_r <= '0;
      off_r <= '0; ilim_r <= '0;
      step_r <= 14'd72;
      alpha_r <= 9'd51;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wspid_pkg::CFG_KP:    kp_r    <= cfg_data;
        wspid_pkg::CFG_KI:    ki_r    <= cfg_data;
        wspid_pkg::CFG_KD:    kd_r    <= cfg_data;
        wspid_pkg::CFG_OFF:   off_r   <= cfg_data[31:0];
        wspid_pkg::CFG_SLOPE: slope_r <= cfg_data;
        wspid_pkg::CFG_ILIM:  ilim_r  <= cfg_data[39:0];
        wspid_pkg::CFG_STEP:  step_r  <= cfg_data[13:0];
        wspid_pkg::CFG_ALPHA: alpha_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < WHEELS; k++) begin
        sp_mem[k] <= '0;
        integ_mem[k] <= '0;
        prev_mem[k] <= '0;
        filt_mem[k] <= '0;
      end
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            wheel_r  <= in_tdata[1:0];
            meas_r   <= in_tdata[15:2];
            target_r <= in_tdata[29:16];
            if (32'(in_tdata[1:0]) >= WHEELS) begin
              duty_r <= '0;
              fs_r <= '0;
              sp_r <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          opnd_r <= ACC_W'(fdiff);
          gain_r <= {3'b000, alpha_eff};
          acc_r <= '0;
          cnt_r <= '0;
          state_r <= S_FILT;
        end
        S_FILT: begin
          acc_r <= acc_step;
          opnd_r <= opnd_r <<< 1;
          gain_r <= gain_r >> 1;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd8) state_r <= S_RAMP;
        end
        S_RAMP: begin
          filt_mem[widx] <= fnew[21:0];
          fs_r <= fnew[21:8];
          sp_mem[widx] <= sp_new;
          sp_r <= sp_new;
          if (target_r == 14'd0 && sp_new == 14'd0) begin
            integ_mem[widx] <= '0;
            prev_mem[widx] <= '0;
            duty_r <= '0;
            state_r <= S_DONE;
          end else begin
            state_r <= S_ERR;
          end
        end
        S_ERR: begin
          e_r <= e_new;
          de_r <= de_new;
          prod_r <= '0;
          state_r <= S_PREP;
        end
        S_PREP: begin
          opnd_r <= p_opnd;
          gain_r <= p_gain;
          cnt_r <= '0;
          if (prod_r == 2'd0) acc_r <= ff_init;
          state_r <= S_MAC;
        end
        S_MAC: begin
          acc_r <= acc_step;
          opnd_r <= opnd_r <<< 1;
          gain_r <= gain_r >> 1;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd11) begin
            if (prod_r == 2'd3) begin
              state_r <= S_UPD;
            end else begin
              prod_r <= prod_r + 2'd1;
              state_r <= S_PREP;
            end
          end
        end
        S_UPD: begin
          prev_mem[widx] <= 16'(e_r);
          if (acc_r <= 0) begin
            duty_r <= '0;
            state_r <= S_DONE;
          end else if (acc_r >= $signed(wspid_pkg::DUTY_SAT)) begin
            duty_r <= 8'hFF;
            state_r <= S_DONE;
          end else begin
            if (ival > $signed({6'd0, lim})) integ_mem[widx] <= 24'({6'd0, lim});
            else if (ival < -$signed({6'd0, lim})) integ_mem[widx] <= 24'(-$signed({6'd0, lim}));
            else integ_mem[widx] <= ival[23:0];
            divx_r <= acc_r[24:14];
            rem_r <= '0;
            quo_r <= '0;
            cnt_r <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= div_ge ? 3'(div_t - 4'd5) : div_t[2:0];
          quo_r <= {quo_r[6:0], div_ge};
          divx_r <= divx_r << 1;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd10) begin
            duty_r <= {quo_r[6:0], div_ge};
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r <= {2'b00, sp_r, fs_r, duty_r, wheel_r};
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
